// ===== rtl/s21rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// s21rfc_pkg
// Shared types and character codes for the reply frame checker.
// ----------------------------------------------------------------------------
package s21rfc_pkg;

    typedef logic [7:0] t_byte;

    // longest frame in bytes before it is judged like a timeout
    localparam int MAX_FRAME_BYTES = 255;

    // item opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // link characters
    localparam t_byte CH_STX = 8'h02;
    localparam t_byte CH_ETX = 8'h03;
    localparam t_byte CH_ACK = 8'h06;
    localparam t_byte CH_NAK = 8'h15;
    localparam t_byte CH_D   = 8'h44;

    localparam int MIN_FULL_FRAME = 6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NAK   = 2'd2,
        ST_NOACK = 2'd3
    } t_status;

    // snapshot of the frame at the item that ends it
    typedef struct packed {
        logic            fire;
        logic            ended_etx;
        logic            stx_seen;
        logic            sum_ok;
        t_byte           count;
        logic [3:0][7:0] head;
        t_byte           cmd_first;
        t_byte           cmd_second;
    } t_frame_view;

    typedef struct packed {
        t_status status;
        logic    send_ack;
        t_byte   payload_len;
    } t_result;

endpackage

// ===== rtl/s21_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// s21_reply_frame_checker
// Byte-wise checker for reply frames on the air-conditioner serial link.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  in       | sink      | i_in_valid / o_in_stall | op, rx_byte, cmd_first,
//           |           |                        | cmd_second, is_set_command
//  out      | source    | o_out_valid / i_out_stall | status, send_ack,
//           |           |                        | payload_len, link_up
//
//  Two register stages: input register, then frame state + judge feeding the
//  result register. One transfer per cycle while the result is not stalled.
//  Reset (synchronous, active low) empties both stages and drops any frame
//  in progress; the checker waits for a start item.
//  A stalled result holds the result register and, through it, the input
//  register; the input side stalls only when its register is occupied.
//
//  A reply frame looks like ACK, STX, cmd+1, cmd2, data..., checksum, ETX.
//  The frame ends on NAK, ETX, ACK (set commands only), timeout or a full
//  frame of MAX_FRAME bytes; only the ending transfer yields a result.
// ----------------------------------------------------------------------------
module s21_reply_frame_checker #(
    parameter int MAX_FRAME = s21rfc_pkg::MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_cmd_first,
    input  logic [7:0] i_cmd_second,
    input  logic       i_is_set_command,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_send_ack,
    output logic [7:0] o_payload_len,
    output logic       o_link_up
);
    import s21rfc_pkg::*;

    // input register
    logic       r_in_valid;
    logic [1:0] r_op;
    t_byte      r_rx_byte;
    t_byte      r_cmd_first;
    t_byte      r_cmd_second;
    logic       r_is_set;

    // result register
    logic       r_out_valid;
    t_result    r_result;

    logic        advance;     // result register may load
    logic        work_en;     // held item goes through the frame logic
    t_frame_view frame_view;
    t_result     judged;

    assign advance    = !(r_out_valid && i_out_stall);
    assign work_en    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op         <= i_op;
            r_rx_byte    <= i_rx_byte;
            r_cmd_first  <= i_cmd_first;
            r_cmd_second <= i_cmd_second;
            r_is_set     <= i_is_set_command;
        end
    end

    s21rfc_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (work_en),
        .i_op             (r_op),
        .i_rx_byte        (r_rx_byte),
        .i_cmd_first      (r_cmd_first),
        .i_cmd_second     (r_cmd_second),
        .i_is_set_command (r_is_set),
        .o_view           (frame_view)
    );

    s21rfc_judge u_judge (
        .i_view   (frame_view),
        .o_result (judged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= work_en && frame_view.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_en && frame_view.fire) begin
            r_result <= judged;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_send_ack    = r_result.send_ack;
    assign o_payload_len = r_result.payload_len;
    // connected flag follows the last verdict
    assign o_link_up     = (r_result.status == ST_OK);

    // ---------------------------------------------------------------- checks
    a_len_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_payload_len == 8'd0))
        else $error("payload length set on a failed frame");

    a_ack_only_ok_or_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_ack) |-> ((o_status == ST_OK) || (o_status == ST_BAD)))
        else $error("ACK requested without a closing ETX");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with no blocked result");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a held item");

endmodule

// ===== rtl/s21rfc_frame_state.sv =====
// ----------------------------------------------------------------------------
// s21rfc_frame_state
// Running frame state: byte count, head bytes, checksum, saved command.
// ----------------------------------------------------------------------------
module s21rfc_frame_state #(
    parameter int MAX_FRAME = s21rfc_pkg::MAX_FRAME_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [1:0]               i_op,
    input  logic [7:0]               i_rx_byte,
    input  logic [7:0]               i_cmd_first,
    input  logic [7:0]               i_cmd_second,
    input  logic                     i_is_set_command,
    output s21rfc_pkg::t_frame_view  o_view
);
    import s21rfc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic            r_receiving, n_receiving;
    logic [CW-1:0]   r_count,     n_count;
    t_byte           r_cmd_first, n_cmd_first;
    t_byte           r_cmd_second, n_cmd_second;
    logic            r_is_set,    n_is_set;
    logic [3:0][7:0] r_head,      n_head;
    t_byte           r_prev,      n_prev;
    t_byte           r_sum,       n_sum;
    logic            r_stx,       n_stx;

    logic [CW-1:0]   cnt_inc;
    logic            byte_end;
    logic            sum_ok;

    assign cnt_inc = r_count + CW'(1);
    // at an ETX the checksum byte is prev; sum of bytes before it is r_sum - prev
    assign sum_ok  = (t_byte'(r_sum - r_prev) == r_prev);
    assign byte_end = (i_rx_byte == CH_ETX) || (i_rx_byte == CH_NAK) ||
                      ((i_rx_byte == CH_ACK) && r_is_set) ||
                      (cnt_inc >= CW'(MAX_FRAME));

    always_comb begin
        n_receiving  = r_receiving;
        n_count      = r_count;
        n_cmd_first  = r_cmd_first;
        n_cmd_second = r_cmd_second;
        n_is_set     = r_is_set;
        n_head       = r_head;
        n_prev       = r_prev;
        n_sum        = r_sum;
        n_stx        = r_stx;

        o_view.fire       = 1'b0;
        o_view.ended_etx  = 1'b0;
        o_view.stx_seen   = r_stx;
        o_view.sum_ok     = sum_ok;
        o_view.count      = 8'(r_count);
        o_view.head       = r_head;
        o_view.cmd_first  = r_cmd_first;
        o_view.cmd_second = r_cmd_second;

        case (i_op)
            OP_START: begin
                n_receiving  = 1'b1;
                n_count      = '0;
                n_cmd_first  = i_cmd_first;
                n_cmd_second = i_cmd_second;
                n_is_set     = i_is_set_command;
                n_head       = '0;
                n_prev       = '0;
                n_sum        = '0;
                n_stx        = 1'b0;
            end
            OP_BYTE: begin
                if (r_receiving) begin
                    if (r_count < CW'(4)) begin
                        n_head[r_count[1:0]] = i_rx_byte;
                    end
                    if (r_count >= CW'(2)) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                    if (i_rx_byte == CH_STX) begin
                        n_stx = 1'b1;
                    end
                    n_count = cnt_inc;
                    if (byte_end) begin
                        n_receiving = 1'b0;
                    end else begin
                        n_prev = i_rx_byte;
                    end
                    o_view.fire      = byte_end;
                    o_view.ended_etx = (i_rx_byte == CH_ETX);
                    o_view.stx_seen  = n_stx;
                    o_view.count     = 8'(cnt_inc);
                    o_view.head      = n_head;
                end
            end
            OP_TIMEOUT: begin
                if (r_receiving) begin
                    n_receiving = 1'b0;
                    o_view.fire = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_count     <= '0;
            r_stx       <= 1'b0;
        end else if (i_en) begin
            r_receiving <= n_receiving;
            r_count     <= n_count;
            r_stx       <= n_stx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd_first  <= n_cmd_first;
            r_cmd_second <= n_cmd_second;
            r_is_set     <= n_is_set;
            r_head       <= n_head;
            r_prev       <= n_prev;
            r_sum        <= n_sum;
        end
    end

endmodule

// ===== rtl/s21rfc_judge.sv =====
// ----------------------------------------------------------------------------
// s21rfc_judge
// Judges a finished frame: status, ACK reply flag and payload length.
// ----------------------------------------------------------------------------
module s21rfc_judge (
    input  s21rfc_pkg::t_frame_view i_view,
    output s21rfc_pkg::t_result     o_result
);
    import s21rfc_pkg::*;

    logic  h0_ack;
    logic  h0_stx;
    logic  head_bad;
    t_byte cmd_inc;

    assign h0_ack  = (i_view.head[0] == CH_ACK);
    assign h0_stx  = (i_view.head[0] == CH_STX);
    assign cmd_inc = i_view.cmd_first + 8'd1;
    // cmd_first of 0xFF would need a reply byte of 0x100: never matches
    assign head_bad = (i_view.head[1] != CH_STX) || (i_view.cmd_first == 8'hFF) ||
                      (i_view.head[2] != cmd_inc) ||
                      (i_view.head[3] != i_view.cmd_second);

    always_comb begin
        o_result.status      = ST_OK;
        o_result.send_ack    = 1'b0;
        o_result.payload_len = i_view.count - 8'd1;

        if (i_view.count == 8'd0) begin
            o_result.status = ST_BAD;
        end else if (!h0_ack && !h0_stx) begin
            o_result.status = (i_view.head[0] == CH_NAK) ? ST_NAK : ST_NOACK;
        end else if (h0_ack && (i_view.cmd_first == CH_D)) begin
            o_result.status = ST_OK;   // lone ACK answers a D command
        end else if (h0_ack && !i_view.stx_seen) begin
            o_result.status = ST_NOACK;
        end else if (!i_view.ended_etx) begin
            o_result.status = ST_NOACK;
        end else begin
            o_result.send_ack = 1'b1;
            if ((i_view.count < 8'(MIN_FULL_FRAME)) || !i_view.sum_ok || head_bad) begin
                o_result.status = ST_BAD;
            end
        end

        if (o_result.status != ST_OK) begin
            o_result.payload_len = '0;
        end
    end

endmodule
